@@ sv/stb_pkg.sv @@
// Shared types and constants of the software timer bank.
// Holds command and result codes, stream payload widths and the count store write control.
// Has no dependencies; every other file but stb_sub imports it.
package stb_pkg;

   // Stream payload widths, including the zero fill up to whole bytes.
   localparam int REQ_DATA_W = 72;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 40;
   localparam int RSP_USER_W = 4;

   // Widths of the payload fields as they appear on the ports.
   localparam int MODE_W   = 3;
   localparam int FIELD_W  = 32;
   localparam int HANDLE_W = 3;
   localparam int KIND_W   = 3;

   // Bound on the expiry results of one tick, and its counter width.
   localparam int MAX_RESULTS = 8;
   localparam int EV_CNT_W    = 4;

   // Command codes carried in the request tuser.
   localparam logic [MODE_W-1:0] MODE_TICK   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_START  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_STOP   = 3'd2;
   localparam logic [MODE_W-1:0] MODE_PAUSE  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_RESUME = 3'd4;
   localparam logic [MODE_W-1:0] MODE_QUERY  = 3'd5;

   // Result kinds carried in the response tuser.
   localparam logic [KIND_W-1:0] KIND_EXPIRED   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_STARTED   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_BANK_FULL = 3'd2;
   localparam logic [KIND_W-1:0] KIND_ELAPSED   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_DONE      = 3'd4;

   // Write enables of the count store.
   typedef struct packed {
      logic init_we;
      logic rem_we;
   } mem_wr_type;

endpackage

@@ sv/software_timer_bank.sv @@
// Software timer bank: a set of down-counting timer slots under a command stream.
// Uses stb_pkg, the shared subtractor stb_sub and the count store stb_count_mem.
//
// Usage. Commands arrive on the req_ stream: tuser holds the command (tick, start,
// stop, pause, resume, query elapsed) and tdata holds the time stamp, slot handle,
// start count and periodic flag. Results leave on the rsp_ stream, one or more per
// command, the final one of each command marked by rsp_tlast.
// A tick walks all slots with one subtract and compare unit, a read state and an update
// state per slot as the count store read is registered; its final result is loaded in
// ST_TICK_END. Other commands load their result in ST_EXEC, a valid query in ST_QUERY once
// the count read is back. req_tready is high only while the sequencer is idle, so the
// next transfer can come in the cycle after the final result is loaded, even while that
// result waits in the output register.
// Expiry results of a tick come out in ascending slot order; one of them is held
// back until the next is found so that the final one can carry tlast. When the
// receiver stalls, the sequencer waits before the transfer that would overwrite
// the output register, so no result is lost.
// Reset (synchronous, active high) frees every slot, clears the tick time stamp
// and empties the output register. The counts need no clearing: a slot's counts
// are written by its start before any read that matters.
module software_timer_bank #(
   parameter int TIMER_SLOTS = 8,
   parameter int TIME_BITS   = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [31:0] now_time, [34:32] timer_slot, [66:35] start_ticks, [67] periodic, rest zero
   input  logic [stb_pkg::REQ_DATA_W-1:0]  req_tdata,
   // [2:0] mode
   input  logic [stb_pkg::REQ_USER_W-1:0]  req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [2:0] slot_index, [34:3] value, rest zero
   output logic [stb_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // [2:0] kind, [3] slot_unused
   output logic [stb_pkg::RSP_USER_W-1:0]  rsp_tuser,
   output logic                            rsp_tlast
);

   import stb_pkg::*;

   localparam int SLOT_W = $clog2(TIMER_SLOTS > 1 ? TIMER_SLOTS : 2);
   localparam int PAD_W  = RSP_DATA_W - FIELD_W - HANDLE_W;

   typedef enum logic [5:0] {
      ST_IDLE     = 6'b000001,
      ST_EXEC     = 6'b000010,
      ST_QUERY    = 6'b000100,
      ST_TICK_RD  = 6'b001000,
      ST_TICK_UPD = 6'b010000,
      ST_TICK_END = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   // Captured command.
   logic [MODE_W-1:0]    mode_ff, mode_in;
   logic [TIME_BITS-1:0] now_ff, now_in;
   logic [HANDLE_W-1:0]  slot_ff, slot_in;
   logic [TIME_BITS-1:0] ticks_ff, ticks_in;
   logic                 per_ff, per_in;

   // Slot flags and tick state.
   logic [TIMER_SLOTS-1:0] in_use_ff, in_use_in;
   logic [TIMER_SLOTS-1:0] running_ff, running_in;
   logic [TIMER_SLOTS-1:0] reload_ff, reload_in;
   logic [TIME_BITS-1:0]   last_stamp_ff, last_stamp_in;
   logic [TIME_BITS-1:0]   elapsed_ff, elapsed_in;
   logic [SLOT_W-1:0]      idx_ff, idx_in;
   logic [EV_CNT_W-1:0]    ev_cnt_ff, ev_cnt_in;
   logic                   pend_valid_ff, pend_valid_in;
   logic [HANDLE_W-1:0]    pend_slot_ff, pend_slot_in;

   // Output register.
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]    rsp_kind_ff;
   logic [HANDLE_W-1:0]  rsp_slot_ff;
   logic [FIELD_W-1:0]   rsp_value_ff;
   logic                 rsp_unused_ff;
   logic                 rsp_last_ff;

   logic                 load_rsp;
   logic [KIND_W-1:0]    res_kind;
   logic [HANDLE_W-1:0]  res_slot;
   logic [FIELD_W-1:0]   res_value;
   logic                 res_unused;
   logic                 res_last;

   // Shared unit and count store connections.
   logic [TIME_BITS-1:0] sub_a;
   logic [TIME_BITS-1:0] sub_b;
   logic [TIME_BITS-1:0] sub_diff;
   logic                 sub_gt;
   mem_wr_type           wr_ctl;
   logic [SLOT_W-1:0]    wr_addr;
   logic [TIME_BITS-1:0] wr_init;
   logic [TIME_BITS-1:0] wr_rem;
   logic [SLOT_W-1:0]    rd_addr;
   logic [TIME_BITS-1:0] rd_init;
   logic [TIME_BITS-1:0] rd_rem;

   // Decode helpers.
   logic                 out_free;
   logic [SLOT_W-1:0]    sidx;
   logic                 slot_ok;
   logic                 any_free;
   logic [SLOT_W-1:0]    free_idx;
   logic                 active;
   logic                 hit;
   logic                 emit;
   logic                 stall;
   logic [TIME_BITS-1:0] new_rem;

   stb_sub #(
      .DATA_W (TIME_BITS)
   ) u_sub (
      .a      (sub_a),
      .b      (sub_b),
      .diff   (sub_diff),
      .a_gt_b (sub_gt)
   );

   stb_count_mem #(
      .SLOTS  (TIMER_SLOTS),
      .DATA_W (TIME_BITS)
   ) u_count_mem (
      .clock   (clock),
      .wr_ctl  (wr_ctl),
      .wr_addr (wr_addr),
      .wr_init (wr_init),
      .wr_rem  (wr_rem),
      .rd_addr (rd_addr),
      .rd_init (rd_init),
      .rd_rem  (rd_rem)
   );

   // The output register can take a new result when empty or being drained.
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);

   // A handle only counts when it lies inside the bank and names a slot in use.
   assign sidx    = SLOT_W'(slot_ff);
   assign slot_ok = (32'(slot_ff) < 32'(TIMER_SLOTS)) && in_use_ff[sidx];

   // Lowest free slot for start.
   always_comb begin
      any_free = 1'b0;
      free_idx = '0;
      for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
         if (!in_use_ff[i]) begin
            any_free = 1'b1;
            free_idx = SLOT_W'(i);
         end
      end
   end

   // Per-slot tick decision; the shared unit compares the remaining count with
   // the elapsed time and gives the reduced count in the same pass.
   assign active = in_use_ff[idx_ff] && running_ff[idx_ff];
   assign hit    = active && !sub_gt;
   assign emit   = hit && (ev_cnt_ff < EV_CNT_W'(MAX_RESULTS));
   assign stall  = emit && pend_valid_ff && !out_free;

   always_comb begin
      if (hit) begin
         new_rem = reload_ff[idx_ff] ? rd_init : '0;
      end else if (active) begin
         new_rem = sub_diff;
      end else begin
         new_rem = rd_rem;
      end
   end

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      now_in        = now_ff;
      slot_in       = slot_ff;
      ticks_in      = ticks_ff;
      per_in        = per_ff;
      in_use_in     = in_use_ff;
      running_in    = running_ff;
      reload_in     = reload_ff;
      last_stamp_in = last_stamp_ff;
      elapsed_in    = elapsed_ff;
      idx_in        = idx_ff;
      ev_cnt_in     = ev_cnt_ff;
      pend_valid_in = pend_valid_ff;
      pend_slot_in  = pend_slot_ff;

      load_rsp   = 1'b0;
      res_kind   = KIND_DONE;
      res_slot   = '0;
      res_value  = '0;
      res_unused = 1'b0;
      res_last   = 1'b1;

      sub_a   = rd_rem;
      sub_b   = elapsed_ff;
      wr_ctl  = '0;
      wr_addr = idx_ff;
      wr_init = ticks_ff;
      wr_rem  = ticks_ff;
      rd_addr = idx_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               mode_in  = req_tuser[MODE_W-1:0];
               now_in   = TIME_BITS'(req_tdata[31:0]);
               slot_in  = req_tdata[34:32];
               ticks_in = TIME_BITS'(req_tdata[66:35]);
               per_in   = req_tdata[67];
               state_in = ST_EXEC;
            end
         end

         ST_EXEC: begin
            sub_a   = now_ff;
            sub_b   = last_stamp_ff;
            rd_addr = sidx;
            case (mode_ff)
               MODE_TICK: begin
                  elapsed_in    = sub_diff;
                  last_stamp_in = now_ff;
                  idx_in        = '0;
                  ev_cnt_in     = '0;
                  pend_valid_in = 1'b0;
                  state_in      = ST_TICK_RD;
               end
               MODE_START: begin
                  if (out_free) begin
                     load_rsp = 1'b1;
                     if (any_free) begin
                        in_use_in[free_idx]  = 1'b1;
                        running_in[free_idx] = 1'b1;
                        reload_in[free_idx]  = per_ff;
                        wr_ctl.init_we       = 1'b1;
                        wr_ctl.rem_we        = 1'b1;
                        wr_addr              = free_idx;
                        res_kind             = KIND_STARTED;
                        res_slot             = HANDLE_W'(free_idx);
                     end else begin
                        res_kind = KIND_BANK_FULL;
                     end
                     state_in = ST_IDLE;
                  end
               end
               MODE_STOP, MODE_PAUSE, MODE_RESUME, MODE_QUERY: begin
                  if (slot_ok && (mode_ff == MODE_QUERY)) begin
                     // Count read issued now, difference formed next cycle.
                     state_in = ST_QUERY;
                  end else if (out_free) begin
                     load_rsp   = 1'b1;
                     res_slot   = slot_ff;
                     res_unused = !slot_ok;
                     if (slot_ok) begin
                        if (mode_ff == MODE_STOP) begin
                           reload_in[sidx]  = 1'b0;
                           running_in[sidx] = 1'b0;
                           wr_ctl.rem_we    = 1'b1;
                           wr_addr          = sidx;
                           wr_rem           = '0;
                        end else if (mode_ff == MODE_PAUSE) begin
                           running_in[sidx] = 1'b0;
                        end else begin
                           running_in[sidx] = 1'b1;
                        end
                     end
                     state_in = ST_IDLE;
                  end
               end
               default: begin
                  if (out_free) begin
                     load_rsp = 1'b1;
                     state_in = ST_IDLE;
                  end
               end
            endcase
         end

         ST_QUERY: begin
            rd_addr = sidx;
            sub_a   = rd_init;
            sub_b   = rd_rem;
            if (out_free) begin
               load_rsp  = 1'b1;
               res_kind  = KIND_ELAPSED;
               res_slot  = slot_ff;
               res_value = FIELD_W'(sub_diff);
               state_in  = ST_IDLE;
            end
         end

         ST_TICK_RD: begin
            state_in = ST_TICK_UPD;
         end

         ST_TICK_UPD: begin
            if (!stall) begin
               // A newly found expiry releases the one held back before it.
               if (emit && pend_valid_ff) begin
                  load_rsp = 1'b1;
                  res_kind = KIND_EXPIRED;
                  res_slot = pend_slot_ff;
                  res_last = 1'b0;
               end
               if (emit) begin
                  pend_valid_in = 1'b1;
                  pend_slot_in  = HANDLE_W'(idx_ff);
                  ev_cnt_in     = ev_cnt_ff + EV_CNT_W'(1);
               end
               if (active) begin
                  wr_ctl.rem_we = 1'b1;
                  wr_rem        = new_rem;
               end
               // One-shot slots that reached zero, stopped ones included, are freed.
               if (in_use_ff[idx_ff] && (new_rem == '0) && !reload_ff[idx_ff]) begin
                  in_use_in[idx_ff]  = 1'b0;
                  running_in[idx_ff] = 1'b0;
               end
               if (idx_ff == SLOT_W'(TIMER_SLOTS - 1)) begin
                  state_in = ST_TICK_END;
               end else begin
                  idx_in   = idx_ff + SLOT_W'(1);
                  state_in = ST_TICK_RD;
               end
            end
         end

         ST_TICK_END: begin
            if (out_free) begin
               load_rsp = 1'b1;
               if (pend_valid_ff) begin
                  res_kind = KIND_EXPIRED;
                  res_slot = pend_slot_ff;
               end
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         in_use_ff     <= '0;
         running_ff    <= '0;
         reload_ff     <= '0;
         last_stamp_ff <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         in_use_ff     <= in_use_in;
         running_ff    <= running_in;
         reload_ff     <= reload_in;
         last_stamp_ff <= last_stamp_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload and working registers.
   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      now_ff       <= now_in;
      slot_ff      <= slot_in;
      ticks_ff     <= ticks_in;
      per_ff       <= per_in;
      elapsed_ff   <= elapsed_in;
      idx_ff       <= idx_in;
      ev_cnt_ff    <= ev_cnt_in;
      pend_slot_ff <= pend_slot_in;
      if (load_rsp) begin
         rsp_kind_ff   <= res_kind;
         rsp_slot_ff   <= res_slot;
         rsp_value_ff  <= res_value;
         rsp_unused_ff <= res_unused;
         rsp_last_ff   <= res_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, rsp_value_ff, rsp_slot_ff};
   assign rsp_tuser  = {rsp_unused_ff, rsp_kind_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

@@ sv/stb_sub.sv @@
// Shared subtract and compare unit of the timer bank.
// Depends on nothing but its width parameter; the sequencer muxes its operands.
module stb_sub #(
   parameter int DATA_W = 32
) (
   input  logic [DATA_W-1:0] a,
   input  logic [DATA_W-1:0] b,
   output logic [DATA_W-1:0] diff,
   output logic              a_gt_b
);

   logic [DATA_W:0] full;

   // The extra top bit is the borrow: set when b exceeds a.
   assign full   = {1'b0, a} - {1'b0, b};
   assign diff   = full[DATA_W-1:0];
   assign a_gt_b = !full[DATA_W] && (full[DATA_W-1:0] != '0);

endmodule

@@ sv/stb_count_mem.sv @@
// Count store of the timer bank: initial and remaining counts, one entry per slot.
// Uses the write control struct from stb_pkg; read data is registered.
module stb_count_mem #(
   parameter int SLOTS  = 8,
   parameter int DATA_W = 32
) (
   input  logic                                   clock,
   input  stb_pkg::mem_wr_type                    wr_ctl,
   input  logic [$clog2(SLOTS > 1 ? SLOTS : 2)-1:0] wr_addr,
   input  logic [DATA_W-1:0]                      wr_init,
   input  logic [DATA_W-1:0]                      wr_rem,
   input  logic [$clog2(SLOTS > 1 ? SLOTS : 2)-1:0] rd_addr,
   output logic [DATA_W-1:0]                      rd_init,
   output logic [DATA_W-1:0]                      rd_rem
);

   import stb_pkg::*;

   logic [DATA_W-1:0] init_mem [SLOTS];
   logic [DATA_W-1:0] rem_mem  [SLOTS];
   logic [DATA_W-1:0] rd_init_ff;
   logic [DATA_W-1:0] rd_rem_ff;

   always_ff @(posedge clock) begin
      if (wr_ctl.init_we) begin
         init_mem[wr_addr] <= wr_init;
      end
      if (wr_ctl.rem_we) begin
         rem_mem[wr_addr] <= wr_rem;
      end
      rd_init_ff <= init_mem[rd_addr];
      rd_rem_ff  <= rem_mem[rd_addr];
   end

   assign rd_init = rd_init_ff;
   assign rd_rem  = rd_rem_ff;

endmodule

@@ bench/timer_bank_check_pkg.sv @@
`timescale 1ns / 1ps
// Command and result records for the timer bank bench, and the scoreboard class that
// keeps its own copy of the slot state to predict every result. Depends on stb_pkg.
package timer_bank_check_pkg;
   import stb_pkg::*;

   localparam int NUM_SLOTS = 8;

   // Modes the block does not define; they must answer done for slot zero.
   localparam logic [MODE_W-1:0] MODE_SPARE_6 = 3'd6;
   localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;

   typedef struct packed {
      logic [MODE_W-1:0]   mode;
      logic [FIELD_W-1:0]  now_time;
      logic [HANDLE_W-1:0] timer_slot;
      logic [FIELD_W-1:0]  start_ticks;
      logic                periodic;
   } timer_cmd_type;

   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [HANDLE_W-1:0] slot_index;
      logic [FIELD_W-1:0]  value;
      logic                slot_unused;
      logic                last;
   } timer_result_type;

   class timer_bank_scoreboard;
      bit                slot_busy[NUM_SLOTS];
      bit                slot_counting[NUM_SLOTS];
      bit                slot_periodic[NUM_SLOTS];
      bit [FIELD_W-1:0]  load_count[NUM_SLOTS];
      bit [FIELD_W-1:0]  count_left[NUM_SLOTS];
      bit [FIELD_W-1:0]  tick_stamp;
      timer_result_type  pending_results[$];
      int                errors;
      int                results_seen;

      function new();
         tick_stamp = '0;
         errors = 0;
         results_seen = 0;
      endfunction

      function timer_result_type make_result(logic [KIND_W-1:0] kind, int slot,
                                             bit [FIELD_W-1:0] value, bit unused);
         timer_result_type r;
         r.kind = kind;
         r.slot_index = HANDLE_W'(slot);
         r.value = value;
         r.slot_unused = unused;
         r.last = 1'b0;
         return r;
      endfunction

      // Updates the slot state for one accepted command and queues its results.
      function void note_command(timer_cmd_type cmd);
         timer_result_type batch[$];
         bit [FIELD_W-1:0] delta;
         int               free_slot;
         int               s;
         int               i;
         s = int'(cmd.timer_slot);
         free_slot = -1;
         case (cmd.mode)
            MODE_TICK: begin
               delta = cmd.now_time - tick_stamp;
               tick_stamp = cmd.now_time;
               for (i = 0; i < NUM_SLOTS; i++) begin
                  if (slot_busy[i] && slot_counting[i]) begin
                     if (count_left[i] > delta) begin
                        count_left[i] = count_left[i] - delta;
                     end else begin
                        count_left[i] = slot_periodic[i] ? load_count[i] : '0;
                        if (batch.size() < MAX_RESULTS)
                           batch.push_back(make_result(KIND_EXPIRED, i, '0, 1'b0));
                     end
                  end
               end
               // One-shot slots that ran out, and stopped slots, are released here.
               for (i = 0; i < NUM_SLOTS; i++) begin
                  if (slot_busy[i] && count_left[i] == 0 && !slot_periodic[i]) begin
                     slot_busy[i] = 1'b0;
                     slot_counting[i] = 1'b0;
                  end
               end
               if (batch.size() == 0)
                  batch.push_back(make_result(KIND_DONE, 0, '0, 1'b0));
            end
            MODE_START: begin
               for (i = NUM_SLOTS - 1; i >= 0; i--) begin
                  if (!slot_busy[i])
                     free_slot = i;
               end
               if (free_slot < 0) begin
                  batch.push_back(make_result(KIND_BANK_FULL, 0, '0, 1'b0));
               end else begin
                  slot_busy[free_slot] = 1'b1;
                  slot_counting[free_slot] = 1'b1;
                  slot_periodic[free_slot] = cmd.periodic;
                  load_count[free_slot] = cmd.start_ticks;
                  count_left[free_slot] = cmd.start_ticks;
                  batch.push_back(make_result(KIND_STARTED, free_slot, '0, 1'b0));
               end
            end
            MODE_STOP, MODE_PAUSE, MODE_RESUME, MODE_QUERY: begin
               if (!slot_busy[s]) begin
                  batch.push_back(make_result(KIND_DONE, s, '0, 1'b1));
               end else if (cmd.mode == MODE_QUERY) begin
                  batch.push_back(make_result(KIND_ELAPSED, s,
                                              load_count[s] - count_left[s], 1'b0));
               end else begin
                  if (cmd.mode == MODE_STOP) begin
                     count_left[s] = '0;
                     slot_periodic[s] = 1'b0;
                  end
                  slot_counting[s] = (cmd.mode == MODE_RESUME);
                  batch.push_back(make_result(KIND_DONE, s, '0, 1'b0));
               end
            end
            default: begin
               batch.push_back(make_result(KIND_DONE, 0, '0, 1'b0));
            end
         endcase
         batch[batch.size() - 1].last = 1'b1;
         foreach (batch[k])
            pending_results.push_back(batch[k]);
      endfunction

      task report_mismatch(string what);
         errors++;
         $display("%t mismatch: %s", $realtime, what);
      endtask

      task check_result(timer_result_type got);
         timer_result_type want;
         results_seen++;
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with none expected (kind %0d)",
                                      results_seen, got.kind));
            return;
         end
         want = pending_results.pop_front();
         if (got.kind !== want.kind)
            report_mismatch($sformatf("result %0d kind %0d, want %0d",
                                      results_seen, got.kind, want.kind));
         if (got.slot_index !== want.slot_index)
            report_mismatch($sformatf("result %0d slot %0d, want %0d",
                                      results_seen, got.slot_index, want.slot_index));
         if (got.value !== want.value)
            report_mismatch($sformatf("result %0d value %h, want %h",
                                      results_seen, got.value, want.value));
         if (got.slot_unused !== want.slot_unused)
            report_mismatch($sformatf("result %0d slot_unused %b, want %b",
                                      results_seen, got.slot_unused, want.slot_unused));
         if (got.last !== want.last)
            report_mismatch($sformatf("result %0d last %b, want %b",
                                      results_seen, got.last, want.last));
      endtask

      task finish_check();
         if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived",
                                      pending_results.size()));
      endtask
   endclass

endpackage

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// Top of the timer bank bench: clock, reset, stream drivers and the run plan.
// Depends on stb_pkg, timer_bank_check_pkg and the block software_timer_bank.
module testbench;
   import stb_pkg::*;
   import timer_bank_check_pkg::*;

   // Random commands after the 24 directed ones, for about 170 in all.
   localparam int RANDOM_ITEMS = 146;
   // The longest command is a tick, which walks all eight slots.
   localparam int SETTLE_CYCLES = 60;
   // Far beyond the slowest correct run, even with the receiver stalling heavily.
   localparam int RUN_LIMIT_NS = 15_000_000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [REQ_USER_W-1:0] req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  rsp_tlast;

   // Percentages of cycles in which the sender holds back and the receiver stalls.
   int send_idle_pct = 0;
   int recv_stall_pct = 0;

   timer_bank_scoreboard timers;

   always #10 clock = ~clock;

   software_timer_bank dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // Offers one command and returns at the edge where its transfer happens. The
   // valid stays high on return, so back-to-back commands never drop it; an idle
   // cycle before the next command, or wait_for_results, is what lowers it.
   task automatic send_command(timer_cmd_type cmd);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'({cmd.periodic, cmd.start_ticks, cmd.timer_slot,
                                 cmd.now_time});
      req_tuser  <= cmd.mode;
      do @(posedge clock); while (!req_tready);
      timers.note_command(cmd);
   endtask

   // Holds the sender back until every result predicted so far has come out.
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (timers.pending_results.size() != 0);
   endtask

   function automatic timer_cmd_type make_command(logic [MODE_W-1:0] mode,
                                                  logic [FIELD_W-1:0] now_time, int slot,
                                                  logic [FIELD_W-1:0] ticks, bit periodic);
      timer_cmd_type cmd;
      cmd.mode = mode;
      cmd.now_time = now_time;
      cmd.timer_slot = HANDLE_W'(slot);
      cmd.start_ticks = ticks;
      cmd.periodic = periodic;
      return cmd;
   endfunction

   // Random commands lean toward what keeps the bank busy: ticks that advance a
   // little past the last stamp, starts with short counts, and slot commands that
   // name slots in use. Fields a command ignores still carry random bits.
   function automatic timer_cmd_type random_command();
      timer_cmd_type cmd;
      int            pick;
      int            busy[$];
      int            i;
      cmd.now_time = $urandom;
      cmd.timer_slot = HANDLE_W'($urandom_range(NUM_SLOTS - 1));
      cmd.start_ticks = $urandom;
      cmd.periodic = 1'($urandom_range(1));
      for (i = 0; i < NUM_SLOTS; i++) begin
         if (timers.slot_busy[i])
            busy.push_back(i);
      end
      pick = $urandom_range(99);
      if (pick < 32) begin
         cmd.mode = MODE_TICK;
         // Now and then a wild stamp, which makes nearly every slot expire.
         if ($urandom_range(19) != 0)
            cmd.now_time = timers.tick_stamp + $urandom_range(60);
      end else if (pick < 56) begin
         cmd.mode = MODE_START;
         if ($urandom_range(9) != 0)
            cmd.start_ticks = $urandom_range(150);
      end else if (pick < 96) begin
         case ($urandom_range(3))
            0: cmd.mode = MODE_STOP;
            1: cmd.mode = MODE_PAUSE;
            2: cmd.mode = MODE_RESUME;
            default: cmd.mode = MODE_QUERY;
         endcase
         if (busy.size() != 0 && $urandom_range(9) != 0)
            cmd.timer_slot = HANDLE_W'(busy[$urandom_range(busy.size() - 1)]);
      end else begin
         cmd.mode = $urandom_range(1) ? MODE_SPARE_6 : MODE_SPARE_7;
      end
      return cmd;
   endfunction

   // Each result transfer is checked against the oldest prediction. Outputs are
   // read right after the edge, so they hold the values the edge itself saw, and
   // the ready for the next cycle is chosen with a single assignment per edge.
   initial begin : result_sink
      timer_result_type got;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            got.kind = rsp_tuser[KIND_W-1:0];
            got.slot_unused = rsp_tuser[KIND_W];
            got.slot_index = rsp_tdata[HANDLE_W-1:0];
            got.value = rsp_tdata[HANDLE_W +: FIELD_W];
            got.last = rsp_tlast;
            timers.check_result(got);
         end
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   initial begin : run_plan
      int n;
      timers = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // First phase: a busy sender against a receiver that mostly stalls.
      send_idle_pct = 13;
      recv_stall_pct = 87;

      // An empty bank: a tick with nothing to expire, commands on free slots, and
      // the two undefined modes.
      send_command(make_command(MODE_TICK, 32'd0, 0, 32'd0, 1'b0));
      send_command(make_command(MODE_QUERY, 32'd0, 3, 32'd0, 1'b0));
      send_command(make_command(MODE_STOP, '1, 0, '1, 1'b1));
      send_command(make_command(MODE_SPARE_6, '1, 7, '1, 1'b1));
      send_command(make_command(MODE_SPARE_7, 32'h5555_5555, 5, 32'hAAAA_AAAA, 1'b0));
      // Fill all eight slots, zero and full-scale counts among them, then overfill.
      send_command(make_command(MODE_START, 32'd0, 0, 32'd0, 1'b0));
      send_command(make_command(MODE_START, 32'd0, 0, '1, 1'b1));
      send_command(make_command(MODE_START, 32'd0, 0, 32'd10, 1'b1));
      send_command(make_command(MODE_START, 32'd0, 0, 32'd5, 1'b0));
      send_command(make_command(MODE_START, 32'd0, 0, 32'd100, 1'b0));
      send_command(make_command(MODE_START, 32'd0, 0, 32'd7, 1'b1));
      send_command(make_command(MODE_START, 32'd0, 0, 32'd1, 1'b0));
      send_command(make_command(MODE_START, 32'd0, 0, 32'd0, 1'b1));
      send_command(make_command(MODE_START, 32'd0, 0, 32'd3, 1'b1));
      send_command(make_command(MODE_PAUSE, 32'd0, 6, 32'd0, 1'b0));
      send_command(make_command(MODE_QUERY, 32'd0, 1, 32'd0, 1'b0));
      // No time passes, yet the slots holding zero still expire.
      send_command(make_command(MODE_TICK, 32'd0, 0, 32'd0, 1'b0));
      send_command(make_command(MODE_TICK, 32'd12, 0, 32'd0, 1'b0));
      send_command(make_command(MODE_QUERY, 32'd0, 4, 32'd0, 1'b0));
      send_command(make_command(MODE_STOP, 32'd0, 4, 32'd0, 1'b0));
      send_command(make_command(MODE_RESUME, 32'd0, 6, 32'd0, 1'b0));
      send_command(make_command(MODE_PAUSE, 32'd0, 2, 32'd0, 1'b0));
      // A huge step to the top of the stamp range, then a step across the wrap.
      send_command(make_command(MODE_TICK, 32'hFFFF_FFF8, 0, 32'd0, 1'b0));
      send_command(make_command(MODE_TICK, 32'h0000_0004, 0, 32'd0, 1'b0));
      wait_for_results();

      for (n = 0; n < RANDOM_ITEMS / 3; n++)
         send_command(random_command());
      wait_for_results();

      // Second phase: a sparse sender against a receiver that rarely stalls.
      send_idle_pct = 87;
      recv_stall_pct = 13;
      for (n = 0; n < RANDOM_ITEMS / 3; n++)
         send_command(random_command());
      wait_for_results();

      // Last phase: full rate on both sides.
      send_idle_pct = 0;
      recv_stall_pct = 0;
      for (n = 0; n < RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3); n++)
         send_command(random_command());
      wait_for_results();

      // Give a stray extra result time to show up before the verdict.
      repeat (SETTLE_CYCLES) @(posedge clock);
      timers.finish_check();
      if (timers.errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin : run_limit
      #(RUN_LIMIT_NS);
      $display("Regression FAIL");
      $finish;
   end

endmodule
